// ----- src/mbnd_pkg.sv -----
// Shared types, constants and helpers for the Manchester / biphase-mark nibble decoder.
// No dependencies; mbnd_decode, mbnd_result_q and the top level use it by scoped names.
package mbnd_pkg;

	// Configuration register indexes
	localparam logic REG_LINE_MODE   = 1'b0;
	localparam logic REG_HALF_SELECT = 1'b1;

	// Line mode codes
	localparam logic MODE_MANCHESTER = 1'b0;
	localparam logic MODE_BIPHASE    = 1'b1;

	// Result queue depth; one item can produce two results
	localparam int unsigned ResQDepth = 4;
	localparam int unsigned ResQAw    = $clog2(ResQDepth);
	localparam int unsigned ResQCw    = $clog2(ResQDepth + 1);

	// One result transaction
	typedef struct packed {
		logic [3:0] data_nibble;
		logic [3:0] error_nibble;
		logic       final_nibble;
	} result_t;

	// Results produced by one item in the decode stage
	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} push_t;

	// Decoder state visible to the top level
	typedef struct packed {
		logic       pair_phase;
		logic       held_valid;
		logic [1:0] symbol_count;
	} dec_status_t;

	// Pad a partial nibble with value-0 / error-1 symbols; cnt symbols already in it.
	// Returns data in bits 7..4 and errors in bits 3..0.
	function automatic logic [7:0] pad_nibble(input logic [1:0] cnt, input logic [3:0] d,
			input logic [3:0] e);
		logic [7:0] r;
		case (cnt)
			2'd1: r = {d << 3, (e << 3) | 4'b0111};
			2'd2: r = {d << 2, (e << 2) | 4'b0011};
			2'd3: r = {d << 1, (e << 1) | 4'b0001};
			default: r = {d, e};
		endcase
		return r;
	endfunction

endpackage

// ----- src/mbnd_in_if.sv -----
// Input channel of the decoder: one half-bit sample per transaction.
// Depends on nothing.
interface mbnd_in_if;
	logic valid;
	logic ready;
	logic half_bit;
	logic end_of_packet;

	modport source (output valid, output half_bit, output end_of_packet, input ready);
	modport sink (input valid, input half_bit, input end_of_packet, output ready);
endinterface

// ----- src/mbnd_out_if.sv -----
// Output channel of the decoder: one data/error nibble pair per transaction.
// Depends on nothing.
interface mbnd_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] data_nibble;
	logic [3:0] error_nibble;
	logic       final_nibble;

	modport source (output valid, output data_nibble, output error_nibble,
		output final_nibble, input ready);
	modport sink (input valid, input data_nibble, input error_nibble,
		input final_nibble, output ready);
endinterface

// ----- src/mbnd_decode.sv -----
// Input register and symbol decode stage: pairs half-bits, packs nibbles, holds one back.
// Depends on mbnd_pkg.
module mbnd_decode (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  logic                 half_bit,
	input  logic                 end_of_packet,
	input  logic                 line_mode,
	input  logic                 half_select,
	output mbnd_pkg::push_t      push,
	output mbnd_pkg::dec_status_t status
);

	// Stage 1 input register
	logic       valid_s1;
	logic       half_bit_s1;
	logic       eop_s1;

	// Per-packet state
	logic       pair_phase_q;
	logic       first_half_q;
	logic       prior_q;
	logic       seen_q;
	logic [1:0] count_q;
	logic [3:0] dshift_q;
	logic [3:0] eshift_q;
	logic       held_valid_q;
	logic [7:0] held_pair_q;

	// Decode signals
	logic       sym;
	logic       value;
	logic       error;
	logic [3:0] dshift_n;
	logic [3:0] eshift_n;
	logic [1:0] count_n;
	logic       full_done;
	logic       new_done;
	logic [7:0] new_pair;
	logic       emit_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			half_bit_s1 <= half_bit;
			eop_s1      <= end_of_packet;
		end
	end

	// Symbol value and error
	always_comb begin
		sym = pair_phase_q;
		if (line_mode == mbnd_pkg::MODE_BIPHASE) begin
			value = first_half_q ^ half_bit_s1;
			error = seen_q & (prior_q == first_half_q);
		end else begin
			value = half_select ? half_bit_s1 : first_half_q;
			error = (first_half_q == half_bit_s1);
		end
	end

	// Shift in, then pad at packet end
	always_comb begin
		dshift_n  = sym ? {dshift_q[2:0], value} : dshift_q;
		eshift_n  = sym ? {eshift_q[2:0], error} : eshift_q;
		count_n   = count_q + {1'b0, sym};
		full_done = sym && (count_n == 2'd0);
		if (full_done) begin
			new_pair = {dshift_n, eshift_n};
			new_done = 1'b1;
		end else if (eop_s1 && (count_n != 2'd0)) begin
			new_pair = mbnd_pkg::pad_nibble(count_n, dshift_n, eshift_n);
			new_done = 1'b1;
		end else begin
			new_pair = {dshift_n, eshift_n};
			new_done = 1'b0;
		end
	end

	// Results of this item: held nibble first, then a final new one
	always_comb begin
		emit_new = eop_s1 && new_done;
		push     = '0;
		if (valid_s1) begin
			if (held_valid_q) begin
				push.first  = '{held_pair_q[7:4], held_pair_q[3:0], eop_s1 && !new_done};
				push.second = '{new_pair[7:4], new_pair[3:0], 1'b1};
				push.count  = emit_new ? 2'd2 : 2'd1;
			end else begin
				push.first  = '{new_pair[7:4], new_pair[3:0], 1'b1};
				push.count  = emit_new ? 2'd1 : 2'd0;
			end
		end
	end

	// State update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_phase_q <= 1'b0;
			first_half_q <= 1'b0;
			prior_q      <= 1'b0;
			seen_q       <= 1'b0;
			count_q      <= 2'd0;
			dshift_q     <= 4'd0;
			eshift_q     <= 4'd0;
			held_valid_q <= 1'b0;
			held_pair_q  <= 8'd0;
		end else if (valid_s1) begin
			if (eop_s1) begin
				pair_phase_q <= 1'b0;
				first_half_q <= 1'b0;
				prior_q      <= 1'b0;
				seen_q       <= 1'b0;
				count_q      <= 2'd0;
				dshift_q     <= 4'd0;
				eshift_q     <= 4'd0;
				held_valid_q <= 1'b0;
				held_pair_q  <= 8'd0;
			end else begin
				pair_phase_q <= ~pair_phase_q;
				if (!sym) begin
					first_half_q <= half_bit_s1;
				end else begin
					prior_q <= half_bit_s1;
					seen_q  <= 1'b1;
				end
				count_q      <= count_n;
				dshift_q     <= dshift_n;
				eshift_q     <= eshift_n;
				held_valid_q <= new_done;
				held_pair_q  <= new_done ? new_pair : 8'd0;
			end
		end
	end

	assign status = '{pair_phase_q, held_valid_q, count_q};

endmodule

// ----- src/mbnd_result_q.sv -----
// Small result queue: takes up to two results a cycle, gives one a cycle.
// Depends on mbnd_pkg.
module mbnd_result_q (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mbnd_pkg::push_t              push,
	input  logic                         pop,
	output mbnd_pkg::result_t            head,
	output logic                         not_empty,
	output logic [mbnd_pkg::ResQCw-1:0]  fill
);

	mbnd_pkg::result_t                mem_q [mbnd_pkg::ResQDepth];
	logic [mbnd_pkg::ResQAw-1:0]      wr_ptr_q;
	logic [mbnd_pkg::ResQAw-1:0]      rd_ptr_q;
	logic [mbnd_pkg::ResQCw-1:0]      fill_q;
	logic [mbnd_pkg::ResQAw-1:0]      wr_ptr_nx;

	assign wr_ptr_nx = wr_ptr_q + mbnd_pkg::ResQAw'(1);

	// Entry writes
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_ptr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_ptr_nx] <= push.second;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + mbnd_pkg::ResQAw'(push.count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + mbnd_pkg::ResQAw'(1);
			end
			fill_q <= fill_q + mbnd_pkg::ResQCw'(push.count) - mbnd_pkg::ResQCw'(pop);
		end
	end

	assign head      = mem_q[rd_ptr_q];
	assign not_empty = (fill_q != '0);
	assign fill      = fill_q;

endmodule

// ----- src/manchester_biphase_nibble_decoder_core.sv -----
// Top level of the Manchester / biphase-mark nibble decoder.
// Depends on mbnd_pkg, mbnd_in_if, mbnd_out_if, mbnd_decode and mbnd_result_q.
//
// Usage:
//   samples carries one half-bit per transaction, end_of_packet on the last one.
//   nibbles carries packed data/error nibbles, first symbol in bit 3; final_nibble
//   marks the last nibble of a packet. A completed nibble is held inside until the
//   next sample arrives, so a nibble leaves no earlier than one sample after it.
//   A result is written into the output queue once the stage-1 input register
//   holds the sample that releases it. Throughput: one sample per cycle while
//   the queue has room; the output gives one nibble per cycle while the receiver
//   is ready. A sample that ends a packet may release two nibbles.
//   The rate is set by a four-entry output queue: samples are accepted while it
//   has room for two results beyond those already on their way.
//   Configuration (line_mode, half_select) is written through cfg_write /
//   cfg_index / cfg_data while no packet is in flight.
//   Reset clears all packet state, the queue and both registers to 0.
//   When the receiver stalls, nibbles wait in the queue and, once it is full,
//   samples are held off; nothing is dropped.
module manchester_biphase_nibble_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	mbnd_in_if.sink     samples,
	mbnd_out_if.source  nibbles,
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic        cfg_data
);

	logic                        line_mode_q;
	logic                        half_select_q;
	logic                        take;
	logic                        pop;
	logic                        not_empty;
	logic [mbnd_pkg::ResQCw-1:0] fill;
	logic [mbnd_pkg::ResQCw:0]   pending;
	mbnd_pkg::push_t             push;
	mbnd_pkg::dec_status_t       status;
	mbnd_pkg::result_t           head;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_mode_q   <= 1'b0;
			half_select_q <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				mbnd_pkg::REG_LINE_MODE:   line_mode_q   <= cfg_data;
				mbnd_pkg::REG_HALF_SELECT: half_select_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Room for the stage-1 item's results plus two more
	assign pending       = {1'b0, fill} + (mbnd_pkg::ResQCw + 1)'(push.count);
	assign samples.ready = (pending <= (mbnd_pkg::ResQCw + 1)'(mbnd_pkg::ResQDepth - 2));
	assign take          = samples.valid && samples.ready;

	mbnd_decode u_decode (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.half_bit      (samples.half_bit),
		.end_of_packet (samples.end_of_packet),
		.line_mode     (line_mode_q),
		.half_select   (half_select_q),
		.push          (push),
		.status        (status)
	);

	mbnd_result_q u_result_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (pop),
		.head      (head),
		.not_empty (not_empty),
		.fill      (fill)
	);

	// Output transaction
	assign nibbles.valid        = not_empty;
	assign nibbles.data_nibble  = head.data_nibble;
	assign nibbles.error_nibble = head.error_nibble;
	assign nibbles.final_nibble = head.final_nibble;
	assign pop                  = nibbles.valid && nibbles.ready;

	// Queue never overfills
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending <= (mbnd_pkg::ResQCw + 1)'(mbnd_pkg::ResQDepth))
		else $error("result queue overflow");

	// A held nibble only exists on a nibble boundary
	a_held_boundary: assert property (@(posedge clk) disable iff (!arst_n)
		status.held_valid |-> (status.symbol_count == 2'd0))
		else $error("held nibble with partial symbols");

	// Packet end returns the decoder to its idle packet state
	a_eop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(take && samples.end_of_packet) |=> ##1
		(!status.pair_phase && !status.held_valid && status.symbol_count == 2'd0))
		else $error("packet state not cleared after packet end");

endmodule
